[sv/clpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_pkg
// Shared types, codes and defaults of the pooled cursor list engine.
// ----------------------------------------------------------------------------
package clpe_pkg;

	localparam int NODE_COUNT_DEF = 256;
	localparam int NUM_HEADS_DEF  = 16;
	localparam int ITEM_BITS_DEF  = 32;

	localparam logic [3:0] ACT_CREATE  = 4'd0;
	localparam logic [3:0] ACT_COUNT   = 4'd1;
	localparam logic [3:0] ACT_FIRST   = 4'd2;
	localparam logic [3:0] ACT_LAST    = 4'd3;
	localparam logic [3:0] ACT_NEXT    = 4'd4;
	localparam logic [3:0] ACT_PREV    = 4'd5;
	localparam logic [3:0] ACT_CURRENT = 4'd6;
	localparam logic [3:0] ACT_ADD     = 4'd7;
	localparam logic [3:0] ACT_INSERT  = 4'd8;
	localparam logic [3:0] ACT_APPEND  = 4'd9;
	localparam logic [3:0] ACT_PREPEND = 4'd10;
	localparam logic [3:0] ACT_REMOVE  = 4'd11;
	localparam logic [3:0] ACT_TRIM    = 4'd12;
	localparam logic [3:0] ACT_CONCAT  = 4'd13;
	localparam logic [3:0] ACT_FREE    = 4'd14;
	localparam logic [3:0] ACT_SEARCH  = 4'd15;

	localparam logic [1:0] PL_EMPTY  = 2'd0;
	localparam logic [1:0] PL_ON     = 2'd1;
	localparam logic [1:0] PL_BEFORE = 2'd2;
	localparam logic [1:0] PL_AFTER  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOITEM = 2'd1;
	localparam logic [1:0] ST_POOL   = 2'd2;
	localparam logic [1:0] ST_NOLIST = 2'd3;

	localparam logic [4:0] UOP_NONE   = 5'd0;
	localparam logic [4:0] UOP_ACCEPT = 5'd1;
	localparam logic [4:0] UOP_HEAD   = 5'd2;
	localparam logic [4:0] UOP_NOFREE = 5'd3;
	localparam logic [4:0] UOP_CREATE = 5'd4;
	localparam logic [4:0] UOP_COUNT  = 5'd5;
	localparam logic [4:0] UOP_MOVE   = 5'd6;
	localparam logic [4:0] UOP_EDGE   = 5'd7;
	localparam logic [4:0] UOP_FETCH  = 5'd8;
	localparam logic [4:0] UOP_POOLE  = 5'd9;
	localparam logic [4:0] UOP_ADD0   = 5'd10;
	localparam logic [4:0] UOP_ADD1   = 5'd11;
	localparam logic [4:0] UOP_ADD2   = 5'd12;
	localparam logic [4:0] UOP_REM    = 5'd13;
	localparam logic [4:0] UOP_TRIM   = 5'd14;
	localparam logic [4:0] UOP_PUSH   = 5'd15;
	localparam logic [4:0] UOP_CAT    = 5'd16;
	localparam logic [4:0] UOP_FREE   = 5'd17;
	localparam logic [4:0] UOP_REL    = 5'd18;
	localparam logic [4:0] UOP_SSTART = 5'd19;
	localparam logic [4:0] UOP_SSTEP  = 5'd20;
	localparam logic [4:0] UOP_DONE   = 5'd21;

	typedef struct packed {
		logic [4:0] uop;
	} cmd_t;

	typedef struct packed {
		logic [3:0] act;
		logic       hok;
		logic       h2ok;
		logic       sz_zero;
		logic [1:0] place;
		logic       c_last;
		logic       c_first;
		logic       c_nil;
		logic       ftop_nil;
		logic       ltop_nil;
		logic       s_start_nil;
		logic       s_hit;
		logic       s_end;
		logic       out_free;
	} stat_t;

endpackage

[sv/clpe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/clpe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_ctrl
// Command sequencer: decodes each request and steps the datapath.
// ----------------------------------------------------------------------------
module clpe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output clpe_pkg::cmd_t  cmd,
	input  clpe_pkg::stat_t stat
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HEAD  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_FETCH = 4'd3;
	localparam logic [3:0] S_ADD1  = 4'd4;
	localparam logic [3:0] S_ADD2  = 4'd5;
	localparam logic [3:0] S_PUSH  = 4'd6;
	localparam logic [3:0] S_REL   = 4'd7;
	localparam logic [3:0] S_SRCH  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.uop  = clpe_pkg::UOP_NONE;
		s_tready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.uop = clpe_pkg::UOP_ACCEPT;
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.uop = clpe_pkg::UOP_HEAD;
				state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_DONE;
				if (stat.act == clpe_pkg::ACT_CREATE) begin
					cmd.uop = stat.ltop_nil ? clpe_pkg::UOP_NOFREE : clpe_pkg::UOP_CREATE;
				end else if (stat.hok) begin
					case (stat.act)
						clpe_pkg::ACT_COUNT: begin
							cmd.uop = clpe_pkg::UOP_COUNT;
						end
						clpe_pkg::ACT_FIRST, clpe_pkg::ACT_LAST: begin
							if (!stat.sz_zero) begin
								cmd.uop = clpe_pkg::UOP_MOVE;
								state_d = S_FETCH;
							end
						end
						clpe_pkg::ACT_NEXT: begin
							if (!stat.sz_zero && stat.place != clpe_pkg::PL_AFTER) begin
								if (stat.place == clpe_pkg::PL_ON && stat.c_last) begin
									cmd.uop = clpe_pkg::UOP_EDGE;
								end else begin
									cmd.uop = clpe_pkg::UOP_MOVE;
									state_d = S_FETCH;
								end
							end
						end
						clpe_pkg::ACT_PREV: begin
							if (!stat.sz_zero && stat.place != clpe_pkg::PL_BEFORE) begin
								if (stat.place == clpe_pkg::PL_ON && stat.c_first) begin
									cmd.uop = clpe_pkg::UOP_EDGE;
								end else begin
									cmd.uop = clpe_pkg::UOP_MOVE;
									state_d = S_FETCH;
								end
							end
						end
						clpe_pkg::ACT_CURRENT: begin
							if (!stat.sz_zero && stat.place == clpe_pkg::PL_ON) begin
								cmd.uop = clpe_pkg::UOP_MOVE;
								state_d = S_FETCH;
							end
						end
						clpe_pkg::ACT_ADD, clpe_pkg::ACT_INSERT,
						clpe_pkg::ACT_APPEND, clpe_pkg::ACT_PREPEND: begin
							if (stat.ftop_nil) begin
								cmd.uop = clpe_pkg::UOP_POOLE;
							end else begin
								cmd.uop = clpe_pkg::UOP_ADD0;
								state_d = S_ADD1;
							end
						end
						clpe_pkg::ACT_REMOVE: begin
							if (!stat.sz_zero && stat.place == clpe_pkg::PL_ON && !stat.c_nil) begin
								cmd.uop = clpe_pkg::UOP_REM;
								state_d = S_PUSH;
							end
						end
						clpe_pkg::ACT_TRIM: begin
							if (!stat.sz_zero) begin
								cmd.uop = clpe_pkg::UOP_TRIM;
								state_d = S_PUSH;
							end
						end
						clpe_pkg::ACT_CONCAT: begin
							if (stat.h2ok) begin
								cmd.uop = clpe_pkg::UOP_CAT;
								state_d = S_REL;
							end
						end
						clpe_pkg::ACT_FREE: begin
							cmd.uop = clpe_pkg::UOP_FREE;
							state_d = S_REL;
						end
						clpe_pkg::ACT_SEARCH: begin
							if (!stat.sz_zero) begin
								cmd.uop = clpe_pkg::UOP_SSTART;
								if (!stat.s_start_nil) begin
									state_d = S_SRCH;
								end
							end
						end
						default: begin
							cmd.uop = clpe_pkg::UOP_NONE;
						end
					endcase
				end
			end
			S_FETCH: begin
				cmd.uop = clpe_pkg::UOP_FETCH;
				state_d = S_DONE;
			end
			S_ADD1: begin
				cmd.uop = clpe_pkg::UOP_ADD1;
				state_d = S_ADD2;
			end
			S_ADD2: begin
				cmd.uop = clpe_pkg::UOP_ADD2;
				state_d = S_DONE;
			end
			S_PUSH: begin
				cmd.uop = clpe_pkg::UOP_PUSH;
				state_d = S_DONE;
			end
			S_REL: begin
				cmd.uop = clpe_pkg::UOP_REL;
				state_d = S_DONE;
			end
			S_SRCH: begin
				cmd.uop = clpe_pkg::UOP_SSTEP;
				if (stat.s_hit || stat.s_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.uop = clpe_pkg::UOP_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/clpe_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_dp
// Datapath: node and list head memories, free stacks, result register.
// ----------------------------------------------------------------------------
module clpe_dp #(
	parameter int NODE_COUNT = clpe_pkg::NODE_COUNT_DEF,
	parameter int NUM_HEADS  = clpe_pkg::NUM_HEADS_DEF,
	parameter int ITEM_BITS  = clpe_pkg::ITEM_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  clpe_pkg::cmd_t  cmd,
	output clpe_pkg::stat_t stat,
	input  logic [39:0]     s_tdata,
	input  logic [3:0]      s_tuser,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata,
	output logic [1:0]      m_tuser
);

	localparam int NA  = $clog2(NODE_COUNT);
	localparam int PW  = $clog2(NODE_COUNT + 1);
	localparam int LB  = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
	localparam int LH  = $clog2(NUM_HEADS + 1);
	localparam int HBW = 4 * PW + 2;

	localparam logic [PW-1:0] NIL_N = PW'(NODE_COUNT);
	localparam logic [LH-1:0] NIL_L = LH'(NUM_HEADS);

	// request
	logic [3:0]           act_q;
	logic [3:0]           h_q;
	logic [3:0]           h2_q;
	logic [ITEM_BITS-1:0] val_q;

	// head of the addressed list
	logic [PW-1:0] hd_first_q, hd_last_q, hd_cur_q, hd_size_q;
	logic [1:0]    hd_place_q;

	logic [LH-1:0] lnext_q;
	logic [PW-1:0] n_q, a_q, b_q, s_q;

	logic [1:0]           rs_status_q;
	logic [ITEM_BITS-1:0] rs_item_q;
	logic [3:0]           rs_newh_q;
	logic [PW-1:0]        rs_cnt_q;

	logic [1:0]           out_status_q;
	logic [ITEM_BITS-1:0] out_item_q;
	logic [3:0]           out_newh_q;
	logic [PW-1:0]        out_cnt_q;
	logic                 out_vld_q;

	logic [PW-1:0]        ftop_q, node_hw_q;
	logic [LH-1:0]        ltop_q, list_hw_q;
	logic [NUM_HEADS-1:0] in_use_q;
	logic [NA-1:0]        next_raddr_q;
	logic [LB-1:0]        lnext_raddr_q;

	// memory ports
	logic                 item_we, next_we, prev_we, head_we, lnext_we;
	logic [NA-1:0]        item_wa, next_wa, prev_wa, item_ra, next_ra, prev_ra;
	logic [ITEM_BITS-1:0] item_wd, item_rdata;
	logic [PW-1:0]        next_wd, prev_wd, next_rdata, prev_rdata;
	logic [LB-1:0]        head_wa, head_ra, lnext_wa, lnext_ra;
	logic [HBW-1:0]       head_wd, head_rdata;
	logic [LH-1:0]        lnext_wd, lnext_rdata;

	logic [PW-1:0] hr_first, hr_last, hr_cur, hr_size;
	logic [1:0]    hr_place;
	logic [PW-1:0] hw_first, hw_last, hw_cur, hw_size;
	logic [1:0]    hw_place;

	logic [PW-1:0] nxt_rd, prev_rd, mv_tgt, ab_a, ab_b, s0, snx, rm_p, rm_nx;
	logic [LH-1:0] lnext_rd;
	logic [3:0]    rel_idx;
	logic          s_hit, sz_zero, hok, h2ok;

	clpe_ram #(.WIDTH(ITEM_BITS), .DEPTH(NODE_COUNT)) u_item_ram (
		.clk(clk), .we(item_we), .waddr(item_wa), .wdata(item_wd),
		.raddr(item_ra), .rdata(item_rdata)
	);

	clpe_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(next_rdata)
	);

	clpe_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(prev_ra), .rdata(prev_rdata)
	);

	clpe_ram #(.WIDTH(HBW), .DEPTH(NUM_HEADS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(head_ra), .rdata(head_rdata)
	);

	clpe_ram #(.WIDTH(LH), .DEPTH(NUM_HEADS)) u_lnext_ram (
		.clk(clk), .we(lnext_we), .waddr(lnext_wa), .wdata(lnext_wd),
		.raddr(lnext_ra), .rdata(lnext_rdata)
	);

	assign hr_first = head_rdata[HBW-1 -: PW];
	assign hr_last  = head_rdata[HBW-PW-1 -: PW];
	assign hr_cur   = head_rdata[HBW-2*PW-1 -: PW];
	assign hr_place = head_rdata[PW+1 -: 2];
	assign hr_size  = head_rdata[PW-1:0];
	assign head_wd  = {hw_first, hw_last, hw_cur, hw_place, hw_size};

	// entries at or above the fill mark read as their reset link (next entry)
	assign nxt_rd = (PW'(next_raddr_q) >= node_hw_q) ?
	                PW'(next_raddr_q) + PW'(1) : next_rdata;
	assign lnext_rd = (LH'(lnext_raddr_q) >= list_hw_q) ?
	                  LH'(lnext_raddr_q) + LH'(1) : lnext_rdata;
	assign prev_rd = prev_rdata;

	assign sz_zero = (hd_size_q == '0);
	assign hok  = (32'(h_q) < 32'(NUM_HEADS)) && in_use_q[LB'(h_q)];
	assign h2ok = (32'(h2_q) < 32'(NUM_HEADS)) && in_use_q[LB'(h2_q)] && (h2_q != h_q);
	assign rel_idx = (act_q == clpe_pkg::ACT_FREE) ? h_q : h2_q;
	assign s_hit = (item_rdata == val_q);
	assign snx   = (s_q == hd_last_q) ? NIL_N : nxt_rd;
	assign rm_p  = prev_rd;
	assign rm_nx = nxt_rd;

	always_comb begin
		case (act_q)
			clpe_pkg::ACT_FIRST: mv_tgt = hd_first_q;
			clpe_pkg::ACT_LAST:  mv_tgt = hd_last_q;
			clpe_pkg::ACT_NEXT:  mv_tgt = (hd_place_q == clpe_pkg::PL_BEFORE) ? hd_first_q : nxt_rd;
			clpe_pkg::ACT_PREV:  mv_tgt = (hd_place_q == clpe_pkg::PL_AFTER) ? hd_last_q : prev_rd;
			default:             mv_tgt = hd_cur_q;
		endcase
	end

	always_comb begin
		ab_a = NIL_N;
		ab_b = NIL_N;
		if (!sz_zero) begin
			if (act_q == clpe_pkg::ACT_APPEND) begin
				ab_a = hd_last_q;
			end else if (act_q == clpe_pkg::ACT_PREPEND) begin
				ab_b = hd_first_q;
			end else if (hd_place_q == clpe_pkg::PL_BEFORE) begin
				ab_b = hd_first_q;
			end else if (hd_place_q == clpe_pkg::PL_AFTER) begin
				ab_a = hd_last_q;
			end else if (act_q == clpe_pkg::ACT_ADD) begin
				ab_a = hd_cur_q;
				ab_b = nxt_rd;
			end else begin
				ab_a = prev_rd;
				ab_b = hd_cur_q;
			end
		end
	end

	always_comb begin
		if (hd_place_q == clpe_pkg::PL_BEFORE) begin
			s0 = hd_first_q;
		end else if (hd_place_q == clpe_pkg::PL_AFTER) begin
			s0 = NIL_N;
		end else begin
			s0 = hd_cur_q;
		end
	end

	always_comb begin
		item_we  = 1'b0;
		next_we  = 1'b0;
		prev_we  = 1'b0;
		head_we  = 1'b0;
		lnext_we = 1'b0;
		item_wa  = NA'(n_q);
		next_wa  = '0;
		prev_wa  = '0;
		head_wa  = LB'(h_q);
		lnext_wa = LB'(rel_idx);
		item_wd  = val_q;
		next_wd  = '0;
		prev_wd  = '0;
		lnext_wd = ltop_q;
		item_ra  = '0;
		next_ra  = '0;
		prev_ra  = '0;
		head_ra  = '0;
		lnext_ra = '0;
		hw_first = hd_first_q;
		hw_last  = hd_last_q;
		hw_cur   = hd_cur_q;
		hw_place = hd_place_q;
		hw_size  = hd_size_q;
		case (cmd.uop)
			clpe_pkg::UOP_ACCEPT: begin
				head_ra  = LB'(s_tdata[3:0]);
				lnext_ra = LB'(ltop_q);
			end
			clpe_pkg::UOP_HEAD: begin
				head_ra = LB'(h2_q);
				item_ra = NA'((act_q == clpe_pkg::ACT_TRIM) ? hr_last : hr_cur);
				next_ra = item_ra;
				prev_ra = item_ra;
			end
			clpe_pkg::UOP_CREATE: begin
				head_we  = 1'b1;
				head_wa  = LB'(ltop_q);
				hw_first = NIL_N;
				hw_last  = NIL_N;
				hw_cur   = NIL_N;
				hw_place = clpe_pkg::PL_EMPTY;
				hw_size  = '0;
			end
			clpe_pkg::UOP_MOVE: begin
				item_ra  = NA'(mv_tgt);
				head_we  = 1'b1;
				hw_cur   = mv_tgt;
				hw_place = clpe_pkg::PL_ON;
			end
			clpe_pkg::UOP_EDGE: begin
				head_we  = 1'b1;
				hw_cur   = NIL_N;
				hw_place = (act_q == clpe_pkg::ACT_NEXT) ? clpe_pkg::PL_AFTER : clpe_pkg::PL_BEFORE;
			end
			clpe_pkg::UOP_ADD0: begin
				next_ra = NA'(ftop_q);
			end
			clpe_pkg::UOP_ADD1: begin
				item_we  = 1'b1;
				next_we  = 1'b1;
				next_wa  = NA'(n_q);
				next_wd  = b_q;
				prev_we  = 1'b1;
				prev_wa  = NA'(n_q);
				prev_wd  = a_q;
				head_we  = 1'b1;
				hw_first = (a_q == NIL_N) ? n_q : hd_first_q;
				hw_last  = (b_q == NIL_N) ? n_q : hd_last_q;
				hw_cur   = n_q;
				hw_place = clpe_pkg::PL_ON;
				hw_size  = hd_size_q + PW'(1);
			end
			clpe_pkg::UOP_ADD2: begin
				next_we = (a_q != NIL_N);
				next_wa = NA'(a_q);
				next_wd = n_q;
				prev_we = (b_q != NIL_N);
				prev_wa = NA'(b_q);
				prev_wd = n_q;
			end
			clpe_pkg::UOP_REM: begin
				next_we  = (rm_p != NIL_N);
				next_wa  = NA'(rm_p);
				next_wd  = rm_nx;
				prev_we  = (rm_nx != NIL_N);
				prev_wa  = NA'(rm_nx);
				prev_wd  = rm_p;
				head_we  = 1'b1;
				hw_first = (rm_p == NIL_N) ? rm_nx : hd_first_q;
				hw_last  = (rm_nx == NIL_N) ? rm_p : hd_last_q;
				if (rm_nx == NIL_N) begin
					hw_place = (rm_p != NIL_N) ? clpe_pkg::PL_AFTER : clpe_pkg::PL_EMPTY;
				end
				hw_cur   = rm_nx;
				hw_size  = hd_size_q - PW'(1);
			end
			clpe_pkg::UOP_TRIM: begin
				next_we  = (rm_p != NIL_N);
				next_wa  = NA'(rm_p);
				next_wd  = NIL_N;
				head_we  = 1'b1;
				hw_first = (rm_p == NIL_N) ? NIL_N : hd_first_q;
				hw_place = (rm_p != NIL_N) ? clpe_pkg::PL_ON : clpe_pkg::PL_EMPTY;
				hw_cur   = rm_p;
				hw_last  = rm_p;
				hw_size  = hd_size_q - PW'(1);
			end
			clpe_pkg::UOP_PUSH: begin
				next_we = 1'b1;
				next_wa = NA'(n_q);
				next_wd = ftop_q;
				prev_we = 1'b1;
				prev_wa = NA'(n_q);
				prev_wd = NIL_N;
			end
			clpe_pkg::UOP_CAT: begin
				if (hr_size != '0) begin
					head_we = 1'b1;
					if (sz_zero) begin
						hw_first = hr_first;
						hw_last  = hr_last;
						hw_size  = hr_size;
						hw_cur   = NIL_N;
						hw_place = clpe_pkg::PL_BEFORE;
					end else begin
						next_we = 1'b1;
						next_wa = NA'(hd_last_q);
						next_wd = hr_first;
						prev_we = 1'b1;
						prev_wa = NA'(hr_first);
						prev_wd = hd_last_q;
						hw_last = hr_last;
						hw_size = hd_size_q + hr_size;
					end
				end
			end
			clpe_pkg::UOP_FREE: begin
				next_we = !sz_zero;
				next_wa = NA'(hd_last_q);
				next_wd = ftop_q;
			end
			clpe_pkg::UOP_REL: begin
				head_we  = 1'b1;
				head_wa  = LB'(rel_idx);
				hw_first = NIL_N;
				hw_last  = NIL_N;
				hw_cur   = NIL_N;
				hw_place = clpe_pkg::PL_EMPTY;
				hw_size  = '0;
				lnext_we = 1'b1;
			end
			clpe_pkg::UOP_SSTART: begin
				item_ra = NA'(s0);
				next_ra = NA'(s0);
				if (s0 == NIL_N) begin
					head_we  = 1'b1;
					hw_cur   = NIL_N;
					hw_place = clpe_pkg::PL_AFTER;
				end
			end
			clpe_pkg::UOP_SSTEP: begin
				item_ra = NA'(snx);
				next_ra = NA'(snx);
				if (s_hit) begin
					head_we  = 1'b1;
					hw_cur   = s_q;
					hw_place = clpe_pkg::PL_ON;
				end else if (snx == NIL_N) begin
					head_we  = 1'b1;
					hw_cur   = NIL_N;
					hw_place = clpe_pkg::PL_AFTER;
				end
			end
			default: begin
				head_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftop_q    <= '0;
			node_hw_q <= '0;
			ltop_q    <= '0;
			list_hw_q <= '0;
			in_use_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (cmd.uop)
				clpe_pkg::UOP_CREATE: begin
					in_use_q[LB'(ltop_q)] <= 1'b1;
					ltop_q <= lnext_q;
					if (ltop_q == list_hw_q) begin
						list_hw_q <= list_hw_q + LH'(1);
					end
				end
				clpe_pkg::UOP_ADD1: begin
					ftop_q <= nxt_rd;
					if (n_q == node_hw_q) begin
						node_hw_q <= node_hw_q + PW'(1);
					end
				end
				clpe_pkg::UOP_PUSH: begin
					ftop_q <= n_q;
				end
				clpe_pkg::UOP_FREE: begin
					if (!sz_zero) begin
						ftop_q <= hd_first_q;
					end
				end
				clpe_pkg::UOP_REL: begin
					in_use_q[LB'(rel_idx)] <= 1'b0;
					ltop_q <= LH'(rel_idx);
				end
				clpe_pkg::UOP_DONE: begin
					out_vld_q <= 1'b1;
				end
				default: begin
					ltop_q <= ltop_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		next_raddr_q  <= next_ra;
		lnext_raddr_q <= lnext_ra;
		case (cmd.uop)
			clpe_pkg::UOP_ACCEPT: begin
				act_q       <= s_tuser;
				h_q         <= s_tdata[3:0];
				h2_q        <= s_tdata[7:4];
				val_q       <= ITEM_BITS'(s_tdata[39:8]);
				rs_status_q <= clpe_pkg::ST_NOITEM;
				rs_item_q   <= '0;
				rs_newh_q   <= '0;
				rs_cnt_q    <= '0;
			end
			clpe_pkg::UOP_HEAD: begin
				hd_first_q <= hr_first;
				hd_last_q  <= hr_last;
				hd_cur_q   <= hr_cur;
				hd_place_q <= hr_place;
				hd_size_q  <= hr_size;
				lnext_q    <= lnext_rd;
			end
			clpe_pkg::UOP_NOFREE: begin
				rs_status_q <= clpe_pkg::ST_NOLIST;
			end
			clpe_pkg::UOP_CREATE: begin
				rs_status_q <= clpe_pkg::ST_OK;
				rs_newh_q   <= 4'(ltop_q);
			end
			clpe_pkg::UOP_COUNT: begin
				rs_status_q <= clpe_pkg::ST_OK;
				rs_cnt_q    <= hd_size_q;
			end
			clpe_pkg::UOP_FETCH: begin
				rs_status_q <= clpe_pkg::ST_OK;
				rs_item_q   <= item_rdata;
			end
			clpe_pkg::UOP_POOLE: begin
				rs_status_q <= clpe_pkg::ST_POOL;
			end
			clpe_pkg::UOP_ADD0: begin
				n_q <= ftop_q;
				a_q <= ab_a;
				b_q <= ab_b;
			end
			clpe_pkg::UOP_ADD2, clpe_pkg::UOP_CAT, clpe_pkg::UOP_FREE: begin
				rs_status_q <= clpe_pkg::ST_OK;
			end
			clpe_pkg::UOP_REM: begin
				rs_status_q <= clpe_pkg::ST_OK;
				rs_item_q   <= item_rdata;
				n_q         <= hd_cur_q;
			end
			clpe_pkg::UOP_TRIM: begin
				rs_status_q <= clpe_pkg::ST_OK;
				rs_item_q   <= item_rdata;
				n_q         <= hd_last_q;
			end
			clpe_pkg::UOP_SSTART: begin
				s_q <= s0;
			end
			clpe_pkg::UOP_SSTEP: begin
				if (s_hit) begin
					rs_status_q <= clpe_pkg::ST_OK;
					rs_item_q   <= item_rdata;
				end else begin
					s_q <= snx;
				end
			end
			clpe_pkg::UOP_DONE: begin
				out_status_q <= rs_status_q;
				out_item_q   <= rs_item_q;
				out_newh_q   <= rs_newh_q;
				out_cnt_q    <= rs_cnt_q;
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

	assign stat.act         = act_q;
	assign stat.hok         = hok;
	assign stat.h2ok        = h2ok;
	assign stat.sz_zero     = sz_zero;
	assign stat.place       = hd_place_q;
	assign stat.c_last      = (hd_cur_q == hd_last_q);
	assign stat.c_first     = (hd_cur_q == hd_first_q);
	assign stat.c_nil       = (hd_cur_q == NIL_N);
	assign stat.ftop_nil    = (ftop_q == NIL_N);
	assign stat.ltop_nil    = (ltop_q == NIL_L);
	assign stat.s_start_nil = (s0 == NIL_N);
	assign stat.s_hit       = s_hit;
	assign stat.s_end       = (snx == NIL_N);
	assign stat.out_free    = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, 9'(out_cnt_q), out_newh_q, 32'(out_item_q)};

endmodule

[sv/cursor_list_pool_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_pool_engine_top
// Pool of nodes shared by several doubly linked lists, each with a cursor.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                       | tuser
//  s_*     | in  | list_handle, second_handle, item_value   | action
//  m_*     | out | item_out, new_handle, count              | status
//
//  A request passes from acceptance through head read, decode, up to two
//  node memory update steps and the result load before the next acceptance.
//  Search adds a step for each node visited (one item memory read).
//  Reset leaves all lists free and every node on the pool; no clearing pass.
//  A result waiting on m_tready holds the engine before its next request.
// ----------------------------------------------------------------------------
module cursor_list_pool_engine_top #(
	parameter int NODE_COUNT = clpe_pkg::NODE_COUNT_DEF,
	parameter int NUM_HEADS  = clpe_pkg::NUM_HEADS_DEF,
	parameter int ITEM_BITS  = clpe_pkg::ITEM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // list_handle, second_handle, item_value
	input  logic [3:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // item_out, new_handle, count, zero pad
	output logic [1:0]  m_tuser   // status
);

	clpe_pkg::cmd_t  cmd;
	clpe_pkg::stat_t stat;

	clpe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.cmd(cmd), .stat(stat)
	);

	clpe_dp #(
		.NODE_COUNT(NODE_COUNT), .NUM_HEADS(NUM_HEADS), .ITEM_BITS(ITEM_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule
